// ===== rtl/core/static_linked_list_manager_top_macros.svh =====
// ----------------------------------------------------------------------------
// static_linked_list_manager_top_macros
// Assertion macros used by the list manager checker.
// ----------------------------------------------------------------------------
`ifndef STATIC_LINKED_LIST_MANAGER_TOP_MACROS_SVH
`define STATIC_LINKED_LIST_MANAGER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("list manager check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SLM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("list manager check failed");

`endif

// ===== rtl/core/slm_pkg.sv =====
// ----------------------------------------------------------------------------
// slm_pkg
// Shared field widths, status codes and action codes of the list manager.
// ----------------------------------------------------------------------------
package slm_pkg;

  localparam int POS_W    = 10;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 10;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t STATUS_DONE   = 2'd0;
  localparam status_t STATUS_RANGE  = 2'd1;
  localparam status_t STATUS_NOFREE = 2'd2;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_DELETE = 1'b1;

endpackage

// ===== rtl/core/slm_ram.sv =====
// ----------------------------------------------------------------------------
// slm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module slm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/static_linked_list_manager_top.sv =====
// ----------------------------------------------------------------------------
// static_linked_list_manager_top
// Ordered list of values in a fixed node store with a free-node chain.
// ----------------------------------------------------------------------------
// Sequence: an error goes straight to the result state; a head insert or
//   delete relinks the head in one state; insert or delete at position p > 1
//   walks the links, one hop a cycle through the single read port of the link RAM.
// Throughput: one item at a time.
// Reset: synchronous, active low; then a clearing pass rebuilds the free
//   chain in the link RAM, during which in_stall is high.
// ----------------------------------------------------------------------------
module static_linked_list_manager_top #(
  parameter int NODE_COUNT = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_action,
  input  logic [slm_pkg::POS_W-1:0]          in_position,
  input  logic signed [slm_pkg::VALUE_W-1:0] in_value,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [slm_pkg::STATUS_W-1:0]       out_status,
  output logic [slm_pkg::LEN_W-1:0]          out_length
);

  // Node index width; also holds the element count (max NODE_COUNT-2).
  localparam int LW   = $clog2(NODE_COUNT);
  // Width wide enough to compare a position against count+1.
  localparam int CMPW = ((LW > slm_pkg::POS_W) ? LW : slm_pkg::POS_W) + 1;
  localparam logic [LW:0] NODES_X = (LW+1)'(NODE_COUNT);

  // Sequencer states
  localparam logic [3:0] ST_CLEAR    = 4'd0;  // post-reset link RAM sweep
  localparam logic [3:0] ST_IDLE     = 4'd1;  // waiting for a transfer
  localparam logic [3:0] ST_INS_FREE = 4'd2;  // pop free chain
  localparam logic [3:0] ST_WALK     = 4'd3;  // follow links, one hop a cycle
  localparam logic [3:0] ST_INS_LINK = 4'd4;  // hook new node after predecessor
  localparam logic [3:0] ST_DEL_HEAD = 4'd5;  // unlink head element
  localparam logic [3:0] ST_DEL_NEXT = 4'd6;  // bypass deleted node
  localparam logic [3:0] ST_DEL_FREE = 4'd7;  // push deleted node on free chain
  localparam logic [3:0] ST_RESP     = 4'd8;  // hand result to output register

  // Out-of-range links read as "no node".
  function automatic logic [LW-1:0] safe_idx(input logic [LW-1:0] x);
    return ({1'b0, x} < NODES_X) ? x : '0;
  endfunction

  logic [3:0]              state_r,      state_nxt;
  logic [LW-1:0]           clr_idx_r,    clr_idx_nxt;
  logic [LW-1:0]           free_head_r,  free_head_nxt;
  logic [LW-1:0]           list_head_r,  list_head_nxt;
  logic [LW-1:0]           count_r,      count_nxt;
  logic [LW-1:0]           cur_r,        cur_nxt;   // walk node; predecessor k at end
  logic [LW-1:0]           j_r,          j_nxt;     // node taken or released
  logic [slm_pkg::POS_W-1:0] rem_r,      rem_nxt;   // hops left in walk
  logic                    act_r,        act_nxt;
  logic                    pos1_r,       pos1_nxt;
  slm_pkg::status_t        status_r,     status_nxt;

  logic                    out_valid_r,  out_valid_nxt;
  slm_pkg::status_t        out_status_r, out_status_nxt;
  logic [slm_pkg::LEN_W-1:0] out_length_r, out_length_nxt;

  // link RAM ports
  logic                    link_we;
  logic [LW-1:0]           link_waddr;
  logic [LW-1:0]           link_wdata;
  logic [LW-1:0]           link_raddr;
  logic [LW-1:0]           link_rdata;
  logic [LW-1:0]           link_next;

  // value RAM write port
  logic                    val_we;

  logic                    in_xfer;
  logic [CMPW-1:0]         pos_x;
  logic [CMPW-1:0]         cnt_x;
  logic                    pos_zero;
  logic                    ins_ok;
  logic                    del_ok;
  logic [LW:0]             clr_idx_x;
  logic [LW-1:0]           clr_link;

  assign in_xfer  = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);

  // Position range checks against the held element count.
  assign pos_x    = CMPW'(in_position);
  assign cnt_x    = CMPW'(count_r);
  assign pos_zero = (in_position == '0);
  assign ins_ok   = !pos_zero && (pos_x <= cnt_x + CMPW'(1));
  assign del_ok   = !pos_zero && (pos_x <= cnt_x);

  // Reset image of the link store: node i -> i+1 for 1 <= i <= NODE_COUNT-3.
  assign clr_idx_x = {1'b0, clr_idx_r};
  assign clr_link  = ((clr_idx_r != '0) && (clr_idx_x + (LW+1)'(2) < NODES_X)) ?
                     (clr_idx_r + LW'(1)) : '0;

  assign link_next = safe_idx(link_rdata);

  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    free_head_nxt  = free_head_r;
    list_head_nxt  = list_head_r;
    count_nxt      = count_r;
    cur_nxt        = cur_r;
    j_nxt          = j_r;
    rem_nxt        = rem_r;
    act_nxt        = act_r;
    pos1_nxt       = pos1_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_length_nxt = out_length_r;
    link_we        = 1'b0;
    link_waddr     = j_r;
    link_wdata     = free_head_r;
    link_raddr     = cur_r;
    val_we         = 1'b0;

    // Result taken downstream frees the output register.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        link_we    = 1'b1;
        link_waddr = clr_idx_r;
        link_wdata = clr_link;
        if (clr_idx_x == NODES_X - (LW+1)'(1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + LW'(1);
        end
      end

      ST_IDLE: begin
        if (in_xfer) begin
          status_nxt = slm_pkg::STATUS_DONE;
          act_nxt    = in_action;
          pos1_nxt   = (in_position == slm_pkg::POS_W'(1));
          rem_nxt    = in_position - slm_pkg::POS_W'(2);
          if (in_action == slm_pkg::ACT_INSERT) begin
            if (!ins_ok) begin
              status_nxt = slm_pkg::STATUS_RANGE;
              state_nxt  = ST_RESP;
            end else if (free_head_r == '0) begin
              status_nxt = slm_pkg::STATUS_NOFREE;
              state_nxt  = ST_RESP;
            end else begin
              // Take the free head and fetch its successor.
              j_nxt      = free_head_r;
              link_raddr = free_head_r;
              val_we     = 1'b1;
              state_nxt  = ST_INS_FREE;
            end
          end else begin
            if (!del_ok) begin
              status_nxt = slm_pkg::STATUS_RANGE;
              state_nxt  = ST_RESP;
            end else if (in_position == slm_pkg::POS_W'(1)) begin
              j_nxt      = list_head_r;
              link_raddr = list_head_r;
              state_nxt  = ST_DEL_HEAD;
            end else begin
              cur_nxt    = list_head_r;
              link_raddr = list_head_r;
              state_nxt  = ST_WALK;
            end
          end
        end
      end

      ST_INS_FREE: begin
        free_head_nxt = link_next;
        if (pos1_r) begin
          link_we       = 1'b1;
          link_waddr    = j_r;
          link_wdata    = list_head_r;
          list_head_nxt = j_r;
          count_nxt     = count_r + LW'(1);
          state_nxt     = ST_RESP;
        end else begin
          cur_nxt    = list_head_r;
          link_raddr = list_head_r;
          state_nxt  = ST_WALK;
        end
      end

      ST_WALK: begin
        // link_rdata holds link[cur_r], read in the previous cycle.
        if (rem_r == '0) begin
          if (act_r == slm_pkg::ACT_INSERT) begin
            link_we    = 1'b1;
            link_waddr = j_r;
            link_wdata = link_next;
            state_nxt  = ST_INS_LINK;
          end else begin
            j_nxt      = link_next;
            link_raddr = link_next;
            state_nxt  = ST_DEL_NEXT;
          end
        end else begin
          cur_nxt    = link_next;
          link_raddr = link_next;
          rem_nxt    = rem_r - slm_pkg::POS_W'(1);
        end
      end

      ST_INS_LINK: begin
        link_we    = 1'b1;
        link_waddr = cur_r;
        link_wdata = j_r;
        count_nxt  = count_r + LW'(1);
        state_nxt  = ST_RESP;
      end

      ST_DEL_HEAD: begin
        list_head_nxt = link_next;
        link_we       = 1'b1;
        link_waddr    = j_r;
        link_wdata    = free_head_r;
        free_head_nxt = j_r;
        count_nxt     = count_r - LW'(1);
        state_nxt     = ST_RESP;
      end

      ST_DEL_NEXT: begin
        link_we    = 1'b1;
        link_waddr = cur_r;
        link_wdata = link_next;
        state_nxt  = ST_DEL_FREE;
      end

      ST_DEL_FREE: begin
        link_we       = 1'b1;
        link_waddr    = j_r;
        link_wdata    = free_head_r;
        free_head_nxt = j_r;
        count_nxt     = count_r - LW'(1);
        state_nxt     = ST_RESP;
      end

      ST_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_length_nxt = slm_pkg::LEN_W'(count_r);
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      free_head_r <= LW'(1);
      list_head_r <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      free_head_r <= free_head_nxt;
      list_head_r <= list_head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and walk registers carry no reset.
  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    j_r          <= j_nxt;
    rem_r        <= rem_nxt;
    act_r        <= act_nxt;
    pos1_r       <= pos1_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_length_r <= out_length_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_length = out_length_r;

  // Next-link store: one write and one registered read per cycle.
  slm_ram #(
    .WIDTH (LW),
    .DEPTH (NODE_COUNT)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (link_we),
    .wr_addr (link_waddr),
    .wr_data (link_wdata),
    .rd_addr (link_raddr),
    .rd_data (link_rdata)
  );

  // Element values; written when a node is taken from the free chain.
  slm_ram #(
    .WIDTH (slm_pkg::VALUE_W),
    .DEPTH (NODE_COUNT)
  ) u_value_ram (
    .clk     (clk),
    .wr_en   (val_we),
    .wr_addr (free_head_r),
    .wr_data (in_value),
    .rd_addr (free_head_r),
    .rd_data ()
  );

endmodule

// ===== rtl/core/slm_checker.sv =====
// ----------------------------------------------------------------------------
// slm_checker
// Port-level checks of the list manager, bound to the top level.
// ----------------------------------------------------------------------------
`include "static_linked_list_manager_top_macros.svh"

module slm_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [slm_pkg::STATUS_W-1:0] out_status,
  input logic [slm_pkg::LEN_W-1:0]    out_length
);

  // Held result stays put while stalled.
  `SLM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_length))

  // Only the three defined status codes appear.
  `SLM_ASSERT_IMPL(a_status_code, clk, rst_n, out_valid, out_status == slm_pkg::STATUS_DONE || out_status == slm_pkg::STATUS_RANGE || out_status == slm_pkg::STATUS_NOFREE)

  // One item in flight: a transfer closes the input side next cycle.
  `SLM_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && !in_stall, in_stall)

  // Clearing pass blocks input right after reset.
  `SLM_ASSERT_IMPL(a_clear_stall, clk, rst_n, $rose(rst_n), in_stall)

endmodule

bind static_linked_list_manager_top slm_checker u_slm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_status (out_status),
  .out_length (out_length)
);
